FILE: rtl/core/gmrm_pkg.sv
// Shared constants and types for the gray ring morphology core.
// No dependencies; imported by the core module.
`timescale 1ns / 1ps
package gmrm_pkg;

  // structuring element: diamond ring at distance HALF_SIZE
  localparam int ELEMENT_SIZE = 11;
  localparam int HALF_SIZE    = ELEMENT_SIZE / 2;
  localparam int RING_ROWS    = 16;
  localparam int SEQ_W        = 4;
  localparam int NUM_TAPS     = 2 * RING_ROWS;

  localparam int PIX_W    = 8;
  localparam int REG_W    = 13;
  localparam int FWIDTH_W = 11;
  localparam int FHEIGHT_W = 13;

  localparam logic [FWIDTH_W-1:0]  FWIDTH_RST  = 11'd640;
  localparam logic [FHEIGHT_W-1:0] FHEIGHT_RST = 13'd480;

  typedef enum logic [1:0] {
    REG_MODE   = 2'd0,
    REG_WIDTH  = 2'd1,
    REG_HEIGHT = 2'd2,
    REG_NONE   = 2'd3
  } reg_idx_e;

  typedef enum logic {
    MODE_MIN = 1'b0,
    MODE_MAX = 1'b1
  } mode_e;

  typedef enum logic {
    CMD_PIXEL = 1'b0,
    CMD_FLUSH = 1'b1
  } cmd_e;

endpackage

FILE: rtl/core/gray_morphology_ring_min_max_core.sv
// Grayscale ring erosion/dilation core: 16 row banks, tap read, min/max tree.
// Depends on gmrm_pkg.
`timescale 1ns / 1ps
// Pipeline: a result word is registered in the bank read register, then in
//   the result register; in stream terms it lags its pixel by 5 rows plus 5
//   pixels, flush words drain the rest.
// Throughput: one input word per cycle while the result stream is not stalled;
//   the 16 dual-read row banks supply all 20 ring taps together in the same read.
// Reset: asynchronous active-low clears counters, valids and config registers;
//   line bank contents stay undefined until written.
module gray_morphology_ring_min_max_core #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // configuration write port
  input  logic                   cfg_we_i,
  input  logic [1:0]             cfg_idx_i,
  input  logic [gmrm_pkg::REG_W-1:0] cfg_wdata_i,
  // input stream
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [7:0]             s_axis_tdata,  // [7:0] pixel
  input  logic                   s_axis_tuser,  // [0] cmd
  // result stream
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [7:0]             m_axis_tdata,  // [7:0] result_pixel
  output logic                   m_axis_tlast   // frame_last
);
  import gmrm_pkg::*;

  localparam int AW      = $clog2(MAX_WIDTH);
  localparam int WW      = $clog2(MAX_WIDTH + 1);
  localparam int LAG_MAX = HALF_SIZE * MAX_WIDTH + HALF_SIZE;
  localparam int PW      = $clog2(LAG_MAX + 2);
  localparam int RW      = FHEIGHT_W + 2;

  // ---------------------------------------------------------------- config
  logic                 mode_q;
  logic [FWIDTH_W-1:0]  fwidth_q;
  logic [FHEIGHT_W-1:0] fheight_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_MIN;
      fwidth_q  <= FWIDTH_RST;
      fheight_q <= FHEIGHT_RST;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_MODE:   mode_q    <= cfg_wdata_i[0];
        REG_WIDTH:  fwidth_q  <= cfg_wdata_i[FWIDTH_W-1:0];
        REG_HEIGHT: fheight_q <= cfg_wdata_i[FHEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // effective geometry: zero counts as one, width saturates at MAX_WIDTH
  logic [WW-1:0]        w_eff;
  logic [FHEIGHT_W-1:0] h_eff;
  logic [PW-1:0]        lag;

  always_comb begin
    if (fwidth_q == '0) w_eff = WW'(1);
    else if (32'(fwidth_q) > 32'(MAX_WIDTH)) w_eff = WW'(MAX_WIDTH);
    else w_eff = WW'(fwidth_q);
    h_eff = (fheight_q == '0) ? FHEIGHT_W'(1) : fheight_q;
    // 5*w + 5
    lag = (PW'(w_eff) << 2) + PW'(w_eff) + PW'(HALF_SIZE);
  end

  // ------------------------------------------------------------- handshake
  logic advance;
  logic accept;
  logic out_valid_q;
  logic b_valid_q;

  assign advance       = !out_valid_q || m_axis_tready;
  assign s_axis_tready = advance;
  assign accept        = s_axis_tvalid && advance;

  // -------------------------------------------------------------- counters
  logic [AW-1:0]        in_col_q, out_col_q;
  logic [FHEIGHT_W-1:0] in_row_q, out_row_q;
  logic [SEQ_W-1:0]     in_seq_q, out_seq_q;
  logic [PW-1:0]        pending_q;

  logic is_pixel;
  logic emit;
  logic wr_en;

  assign is_pixel = (cmd_e'(s_axis_tuser) == CMD_PIXEL);
  assign wr_en    = accept && is_pixel;

  always_comb begin
    if (!accept) emit = 1'b0;
    else if (is_pixel) emit = ({1'b0, pending_q} + 1'b1) > {1'b0, lag};
    else emit = (pending_q != '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q  <= '0;
      in_row_q  <= '0;
      in_seq_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
      out_seq_q <= '0;
      pending_q <= '0;
    end else begin
      // input raster position advances on pixel words
      if (wr_en) begin
        if ((WW'(in_col_q) + 1'b1) >= w_eff) begin
          in_col_q <= '0;
          in_seq_q <= in_seq_q + 1'b1;
          in_row_q <= ((RW'(in_row_q) + 1'b1) >= RW'(h_eff)) ? '0 : in_row_q + 1'b1;
        end else begin
          in_col_q <= in_col_q + 1'b1;
        end
      end
      // pending: +1 per pixel, -1 per result
      if (accept) begin
        case ({wr_en, emit})
          2'b10:   pending_q <= pending_q + 1'b1;
          2'b01:   pending_q <= pending_q - 1'b1;
          default: pending_q <= pending_q;
        endcase
      end
      if (emit) begin
        if ((WW'(out_col_q) + 1'b1) >= w_eff) begin
          out_col_q <= '0;
          out_seq_q <= out_seq_q + 1'b1;
          out_row_q <= ((RW'(out_row_q) + 1'b1) >= RW'(h_eff)) ? '0 : out_row_q + 1'b1;
        end else begin
          out_col_q <= out_col_q + 1'b1;
        end
      end
    end
  end

  // ----------------------------------------------- tap addressing per bank
  // Bank b holds ring slot b; its row offset from the output row is
  // (b - out_seq) mod 16, used when in -5..5. Each bank reads the two
  // columns out_col -/+ (5 - |dr|); at |dr| == 5 only the low port counts.
  // Both columns must fall inside the current width, which matters once the
  // width shrinks while the output column is still past the new edge.
  logic [AW-1:0] addr_lo [RING_ROWS];
  logic [AW-1:0] addr_hi [RING_ROWS];
  logic [RING_ROWS-1:0] ok_lo, ok_hi;
  logic frame_last;

  always_comb begin
    logic [SEQ_W-1:0]      d;
    logic [2:0]            ad;
    logic [2:0]            k;
    logic                  in_use;
    logic signed [RW-1:0]  dr;
    logic signed [RW-1:0]  r;
    logic                  row_ok;
    logic [WW:0]           hi_sum;
    for (int b = 0; b < RING_ROWS; b++) begin
      d      = SEQ_W'(b) - out_seq_q;
      in_use = (d <= SEQ_W'(HALF_SIZE)) || (d >= SEQ_W'(RING_ROWS - HALF_SIZE));
      if (d <= SEQ_W'(HALF_SIZE)) begin
        ad = d[2:0];
        dr = RW'(d);
      end else begin
        ad = 3'(SEQ_W'(0) - d);
        dr = RW'(0) - RW'(3'(SEQ_W'(0) - d));
      end
      k      = 3'(HALF_SIZE) - ad;
      r      = $signed(RW'(out_row_q)) + dr;
      row_ok = in_use && (r >= 0) && (r < $signed(RW'(h_eff)));
      hi_sum = (WW+1)'(out_col_q) + (WW+1)'(k);
      addr_lo[b] = out_col_q - AW'(k);
      addr_hi[b] = AW'(hi_sum);
      ok_lo[b]   = row_ok && (out_col_q >= AW'(k)) && (WW'(addr_lo[b]) < w_eff);
      ok_hi[b]   = row_ok && (k != 3'd0) && (hi_sum < (WW+1)'(w_eff));
    end
    frame_last = ((RW'(out_row_q) + 1'b1) == RW'(h_eff)) &&
                 ((WW'(out_col_q) + 1'b1) == w_eff);
  end

  // ----------------------------------------------------------- line banks
  // Write-first on a same-address collision keeps the read ordering of a
  // store that is written before it is read.
  logic [PIX_W-1:0] rd_lo_q [RING_ROWS];
  logic [PIX_W-1:0] rd_hi_q [RING_ROWS];

  for (genvar gb = 0; gb < RING_ROWS; gb++) begin : g_bank
    logic [PIX_W-1:0] mem [MAX_WIDTH];
    logic             bank_we;

    assign bank_we = wr_en && (in_seq_q == SEQ_W'(gb));

    always_ff @(posedge clk_i) begin
      if (bank_we) mem[in_col_q] <= s_axis_tdata;
    end

    always_ff @(posedge clk_i) begin
      if (advance) begin
        rd_lo_q[gb] <= (bank_we && in_col_q == addr_lo[gb]) ? s_axis_tdata : mem[addr_lo[gb]];
        rd_hi_q[gb] <= (bank_we && in_col_q == addr_hi[gb]) ? s_axis_tdata : mem[addr_hi[gb]];
      end
    end
  end

  // ----------------------------------------------------- read stage flags
  logic [RING_ROWS-1:0] b_ok_lo_q, b_ok_hi_q;
  logic                 b_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (advance) begin
      b_valid_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      b_ok_lo_q <= ok_lo;
      b_ok_hi_q <= ok_hi;
      b_last_q  <= frame_last;
    end
  end

  // ---------------------------------------------------------- min/max tree
  // Masked taps take the neutral value; heap-ordered tree, leaves at 32..63.
  logic [PIX_W-1:0] tree [2*NUM_TAPS];
  logic [PIX_W-1:0] neutral;

  always_comb begin
    neutral = (mode_q == MODE_MAX) ? '0 : '1;
    tree[0] = neutral;
    for (int b = 0; b < RING_ROWS; b++) begin
      tree[NUM_TAPS + 2*b]     = b_ok_lo_q[b] ? rd_lo_q[b] : neutral;
      tree[NUM_TAPS + 2*b + 1] = b_ok_hi_q[b] ? rd_hi_q[b] : neutral;
    end
    for (int n = NUM_TAPS - 1; n >= 1; n--) begin
      if (mode_q == MODE_MAX)
        tree[n] = (tree[2*n] > tree[2*n+1]) ? tree[2*n] : tree[2*n+1];
      else
        tree[n] = (tree[2*n] < tree[2*n+1]) ? tree[2*n] : tree[2*n+1];
    end
  end

  // -------------------------------------------------------- result register
  logic [PIX_W-1:0] out_pix_q;
  logic             out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= b_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_pix_q  <= tree[1];
      out_last_q <= b_last_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_pix_q;
  assign m_axis_tlast  = out_last_q;

  // -------------------------------------------------------------- checks
  a_pending_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(pending_q) <= LAG_MAX)
    else $error("pending count above maximum lag");

  a_flush_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !is_pixel && pending_q == '0) |=> !b_valid_q)
    else $error("flush produced a result with nothing pending");

  a_read_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (b_valid_q && !advance) |=> b_valid_q)
    else $error("read stage dropped a result while stalled");

endmodule
